// ----- rtl/huffman_table_encoder_macros.svh -----
// Assertion macros shared by the Huffman table encoder modules.
`ifndef HUFFMAN_TABLE_ENCODER_MACROS_SVH
`define HUFFMAN_TABLE_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTE_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hte_pkg.sv -----
// Types and constants shared by the Huffman table encoder modules.
package hte_pkg;

    localparam int KIND_W    = 2;
    localparam int SYM_W     = 8;
    localparam int CODE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int BYTE_W    = 8;
    localparam int PEND_W    = 7;
    localparam int CNT_W     = 3;
    localparam int STREAM_W  = CODE_W + BYTE_W;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } req_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_byte;
    } res_word_t;

    // Request after the table lookup, handed from the table to the packer.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              hit;
        logic [LEN_W-1:0]  code_len;
        logic [CODE_W-1:0] code_word;
    } code_item_t;

endpackage

// ----- rtl/hte_code_table.sv -----
// Code table stage: loads entries and looks up the code for each request.
module hte_code_table #(
    parameter int SYMBOL_COUNT = 256,
    parameter int LEN_LIMIT    = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  hte_pkg::req_word_t req_data,
    output logic               item_valid,
    input  logic               item_ready,
    output hte_pkg::code_item_t item
);
    import hte_pkg::*;

    localparam int IDX_W       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int ENTRY_LEN_W = $clog2(LEN_LIMIT + 1);
    localparam int ENTRY_W     = ENTRY_LEN_W + LEN_LIMIT;

    logic [ENTRY_W-1:0]      code_mem [SYMBOL_COUNT];
    logic [ENTRY_W-1:0]      rd_entry_reg;
    logic [SYMBOL_COUNT-1:0] written_reg;
    logic [SYMBOL_COUNT-1:0] written_next;
    logic                    item_valid_reg;
    logic                    item_valid_next;
    logic [KIND_W-1:0]       kind_reg;
    logic                    hit_reg;
    logic                    req_accept;
    logic                    in_range;
    logic [IDX_W-1:0]        sym_idx;
    logic [LEN_W-1:0]        sat_len;
    logic                    do_load;
    logic [ENTRY_LEN_W-1:0]  rd_len;
    logic [LEN_LIMIT-1:0]    rd_word;

    // The stage takes a new word whenever its register is empty or being drained.
    assign req_ready  = !item_valid_reg || item_ready;
    assign req_accept = req_valid && req_ready;

    // Symbol decode and length saturation.
    assign in_range = {1'b0, req_data.symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
    assign sym_idx  = req_data.symbol[IDX_W-1:0];
    assign sat_len  = (req_data.code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                                 : req_data.code_length;
    assign do_load  = req_accept && (req_data.kind == KIND_LOAD) && in_range;

    // Code memory: written by loads, read on every accepted word.
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            code_mem[sym_idx] <= {ENTRY_LEN_W'(sat_len), req_data.code_bits[LEN_LIMIT-1:0]};
        end
        if (req_accept)
        begin
            rd_entry_reg <= code_mem[sym_idx];
        end
    end

    // Written flags stand in for the cleared length table after reset.
    always_comb
    begin
        written_next = written_reg;
        if (do_load)
        begin
            written_next[sym_idx] = 1'b1;
        end
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (req_accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            item_valid_reg <= 1'b0;
            kind_reg       <= KIND_LOAD;
            hit_reg        <= 1'b0;
        end
        else
        begin
            written_reg    <= written_next;
            item_valid_reg <= item_valid_next;
            if (req_accept)
            begin
                kind_reg <= req_data.kind;
                hit_reg  <= in_range && written_reg[sym_idx];
            end
        end
    end

    // A miss reads as an absent symbol with zero length.
    assign rd_len  = rd_entry_reg[ENTRY_W-1:LEN_LIMIT];
    assign rd_word = rd_entry_reg[LEN_LIMIT-1:0];

    assign item_valid     = item_valid_reg;
    assign item.kind      = kind_reg;
    assign item.hit       = hit_reg;
    assign item.code_len  = hit_reg ? LEN_W'(rd_len) : '0;
    assign item.code_word = hit_reg ? CODE_W'(rd_word) : '0;

endmodule

// ----- rtl/hte_packer.sv -----
// Bit packer: appends code bits to the pending byte and emits full bytes.
`include "huffman_table_encoder_macros.svh"

module hte_packer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  hte_pkg::code_item_t item,
    output logic                res_valid,
    input  logic                res_ready,
    output hte_pkg::res_word_t  res_data
);
    import hte_pkg::*;

    localparam int BURST_W = CODE_W;
    localparam int REM_W   = 3;

    logic [BURST_W-1:0]  burst_reg;
    logic [BURST_W-1:0]  burst_next;
    logic [REM_W-1:0]    remain_reg;
    logic [REM_W-1:0]    remain_next;
    logic [PEND_W-1:0]   pend_bits_reg;
    logic [PEND_W-1:0]   pend_bits_next;
    logic [CNT_W-1:0]    pend_cnt_reg;
    logic [CNT_W-1:0]    pend_cnt_next;
    logic                res_accept;
    logic                burst_free;
    logic                take;
    logic [LEN_W-1:0]    total;
    logic [CODE_W-1:0]   word_mask;
    logic [STREAM_W-1:0] stream;
    logic [STREAM_W-1:0] aligned;
    logic [PEND_W-1:0]   enc_pend;
    logic [BYTE_W-1:0]   flush_byte;

    // Output is the top byte of the burst register.
    assign res_valid          = remain_reg != '0;
    assign res_data.out_byte  = burst_reg[BURST_W-1 -: BYTE_W];
    assign res_data.last_byte = remain_reg == REM_W'(1);
    assign res_accept         = res_valid && res_ready;

    // A new word may enter once the last byte of the current burst leaves.
    assign burst_free = (remain_reg == '0) || ((remain_reg == REM_W'(1)) && res_ready);
    assign item_ready = burst_free;
    assign take       = item_valid && burst_free;

    // Join pending bits and code bits into one stream, earliest bit highest.
    assign total     = LEN_W'(pend_cnt_reg) + item.code_len;
    assign word_mask = ~({CODE_W{1'b1}} << item.code_len);
    assign stream    = (STREAM_W'(pend_bits_reg) << item.code_len)
                     | STREAM_W'(item.code_word & word_mask);
    assign aligned   = stream << (LEN_W'(STREAM_W) - total);
    assign enc_pend  = stream[PEND_W-1:0] & ~({PEND_W{1'b1}} << total[CNT_W-1:0]);

    // Flush pads the pending bits with zeros on the right.
    assign flush_byte = {1'b0, pend_bits_reg} << (4'(BYTE_W) - {1'b0, pend_cnt_reg});

    always_comb
    begin
        burst_next     = res_accept ? (burst_reg << BYTE_W) : burst_reg;
        remain_next    = remain_reg - REM_W'(res_accept);
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (take)
        begin
            unique case (item.kind)
                KIND_ENCODE:
                begin
                    burst_next     = aligned[STREAM_W-1 -: BURST_W];
                    remain_next    = total[LEN_W-1:CNT_W];
                    pend_bits_next = enc_pend;
                    pend_cnt_next  = total[CNT_W-1:0];
                end
                KIND_FLUSH:
                begin
                    burst_next     = {flush_byte, {(BURST_W - BYTE_W){1'b0}}};
                    remain_next    = (pend_cnt_reg != '0) ? REM_W'(1) : '0;
                    pend_bits_next = '0;
                    pend_cnt_next  = '0;
                end
                default:
                begin
                    remain_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg    <= '0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end
        else
        begin
            remain_reg    <= remain_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        burst_reg <= burst_next;
    end

    // A burst that still holds bytes keeps offering them.
    `HTE_ASSERT_NEXT(a_burst_continues, res_accept && (remain_reg > REM_W'(1)), res_valid, "burst dropped bytes")
    // A flush always leaves the accumulator empty.
    `HTE_ASSERT_NEXT(a_flush_clears, take && (item.kind == KIND_FLUSH), pend_cnt_reg == '0, "flush left pending bits")
    // Pending bits above the pending count are always zero.
    `HTE_ASSERT_IMPLIES(a_pend_clean, 1'b1, (pend_bits_reg & ({PEND_W{1'b1}} << pend_cnt_reg)) == '0, "stray pending bits")
    // An absent symbol produces no output word.
    `HTE_ASSERT_NEXT(a_miss_silent, take && !item.hit && (item.kind == KIND_ENCODE), !res_valid, "absent symbol emitted a word")

endmodule

// ----- rtl/huffman_table_encoder.sv -----
// Top level of the Huffman table encoder with MSB-first byte packing.
//
// Request channel (req_valid/req_ready/req_data) carries one word per item:
// a load writes one code table entry, an encode appends the code of a symbol
// to the bit stream, a flush pads the pending partial byte with zeros.
// Result channel (res_valid/res_ready/res_data) carries one packed byte per
// word; last_byte marks the final byte caused by a request.
// The first byte of a request is offered from the packer burst register, loaded
// from the table read register; the result port moves one byte a cycle.
// Throughput: one request per cycle while each request yields at most one
// byte and the receiver is ready; a request of N bytes holds the packer until
// its last byte leaves. Codes of up to 32 bits give up to four bytes.
// Reset clears the pending bits and marks every table entry unwritten at once,
// so no clearing pass is needed and requests are taken right after reset.
// When the receiver stalls, the burst register holds its byte and the stall
// backs up through the table stage to req_ready; nothing is lost.
module huffman_table_encoder #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  hte_pkg::req_word_t req_data,
    output logic               res_valid,
    input  logic               res_ready,
    output hte_pkg::res_word_t res_data
);
    import hte_pkg::*;

    localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    logic       item_valid;
    logic       item_ready;
    code_item_t item;

    // Table lookup stage.
    hte_code_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .LEN_LIMIT    (LEN_LIMIT)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // Packing and output stage.
    hte_packer u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

endmodule

// ----- bench/huffman_table_encoder_tb.sv -----
// Self-checking testbench for the Huffman table encoder: code loads, packing, flushes.
module huffman_table_encoder_tb;

    import hte_pkg::*;

    // Kind code that the block must ignore.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    // Longest code length that the table keeps after saturation.
    localparam int LEN_LIMIT = 32;
    // Number of symbols that the stream mostly works on.
    localparam int POOL_SIZE = 16;
    // Cycle count at which the run is abandoned.
    localparam int CYCLE_LIMIT = 300000;
    // Cycles to wait after the last expected byte before the final verdict.
    localparam int TAIL_CYCLES = 20;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_word_t req_data = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    res_word_t res_data;

    // Predicted encoder state.
    bit [CODE_W-1:0] word_tab [256];
    bit [LEN_W-1:0]  len_tab [256];
    bit [PEND_W-1:0] pend_bits;
    bit [CNT_W-1:0]  pend_cnt;

    res_word_t       expected_bytes[$];
    int              mismatch_count = 0;
    int              cycle_count = 0;
    bit              no_idle = 1'b0;
    bit [SYM_W-1:0]  sym_pool [POOL_SIZE];

    huffman_table_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // Clock with a period of ten time units.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver stalls at random, about 18 times in a hundred, unless idling is off.
    always @(posedge clk)
    begin
        res_ready <= no_idle || ($urandom_range(0, 99) >= 18);
    end

    // Compare each accepted byte with the oldest expectation and watch the cycle limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else if (rst_n && res_valid && res_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected word: out_byte %0h, last_byte %0b",
                       res_data.out_byte, res_data.last_byte);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                if (res_data.out_byte !== expected_bytes[0].out_byte)
                begin
                    $error("out_byte: expected %0h, actual %0h",
                           expected_bytes[0].out_byte, res_data.out_byte);
                    mismatch_count = mismatch_count + 1;
                end
                if (res_data.last_byte !== expected_bytes[0].last_byte)
                begin
                    $error("last_byte: expected %0b, actual %0b",
                           expected_bytes[0].last_byte, res_data.last_byte);
                    mismatch_count = mismatch_count + 1;
                end
                void'(expected_bytes.pop_front());
            end
        end
    end

    function automatic req_word_t make_word(input logic [KIND_W-1:0] kind,
                                            input logic [SYM_W-1:0] sym,
                                            input logic [CODE_W-1:0] code,
                                            input logic [LEN_W-1:0] len);
        req_word_t w;
        w.kind        = kind;
        w.symbol      = sym;
        w.code_bits   = code;
        w.code_length = len;
        return w;
    endfunction

    // Update the predicted table and bit packer for one accepted word and queue its bytes.
    task automatic predict_packing(input req_word_t w);
        int unsigned     len;
        bit [CODE_W-1:0] code;
        bit [7:0]        acc;
        int              cnt;
        int              n;
        bit [7:0]        bytes_out [4];
        res_word_t       r;
        n = 0;
        case (w.kind)
            KIND_LOAD:
            begin
                len = 32'(w.code_length);
                if (len > LEN_LIMIT)
                    len = LEN_LIMIT;
                word_tab[w.symbol] = w.code_bits;
                len_tab[w.symbol]  = len[LEN_W-1:0];
            end
            KIND_ENCODE:
            begin
                len  = 32'(len_tab[w.symbol]);
                code = word_tab[w.symbol];
                acc  = {1'b0, pend_bits};
                cnt  = 32'(pend_cnt);
                // Shift the code in from its top bit; every full byte goes out.
                for (int i = len; i > 0; i--)
                begin
                    acc = {acc[6:0], code[i-1]};
                    cnt++;
                    if (cnt == 8)
                    begin
                        bytes_out[n] = acc;
                        n++;
                        acc = '0;
                        cnt = 0;
                    end
                end
                pend_bits = acc[PEND_W-1:0];
                pend_cnt  = cnt[CNT_W-1:0];
            end
            KIND_FLUSH:
            begin
                // Pad the partial byte with zeros below the pending bits.
                if (pend_cnt != 0)
                begin
                    acc = {1'b0, pend_bits};
                    acc = acc << (8 - pend_cnt);
                    bytes_out[0] = acc;
                    n = 1;
                end
                pend_bits = '0;
                pend_cnt  = '0;
            end
            default:
            begin
            end
        endcase
        for (int k = 0; k < n; k++)
        begin
            r.out_byte  = bytes_out[k];
            r.last_byte = (k == n - 1);
            expected_bytes.push_back(r);
        end
    endtask

    // Offer one word, idling first at random, and predict it once accepted.
    task automatic send_word(input req_word_t w);
        if (!no_idle && ($urandom_range(0, 99) < 18))
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 18);
        end
        req_valid <= 1'b1;
        req_data  <= w;
        do
            @(posedge clk);
        while (!req_ready);
        predict_packing(w);
    endtask

    // Hold the sender off until every expected byte has come back.
    task automatic wait_drained;
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_bytes.size() != 0);
    endtask

    // Encodes on an empty table, an empty flush and the unused kind give nothing.
    task automatic test_empty_table;
        send_word(make_word(KIND_ENCODE, 8'h00, '1, '1));
        send_word(make_word(KIND_ENCODE, 8'hFF, '0, '0));
        send_word(make_word(KIND_FLUSH, 8'h5A, '1, '1));
        send_word(make_word(KIND_UNUSED, 8'hFF, '1, '1));
        wait_drained();
    endtask

    // Extreme lengths and codes, saturation, zero lengths and byte boundaries.
    task automatic test_directed_codes;
        send_word(make_word(KIND_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32));
        send_word(make_word(KIND_LOAD, 8'hFF, 32'h0000_0001, 6'd1));
        send_word(make_word(KIND_LOAD, 8'h55, 32'h0000_00A5, 6'd8));
        // Overlong lengths saturate to the full code word.
        send_word(make_word(KIND_LOAD, 8'hAA, 32'hDEAD_BEEF, 6'd63));
        send_word(make_word(KIND_LOAD, 8'h01, 32'h1234_5678, 6'd33));
        // A zero length marks the symbol absent whatever its code.
        send_word(make_word(KIND_LOAD, 8'h02, 32'hFFFF_FFFF, 6'd0));
        // Code bits above the length must not leak out.
        send_word(make_word(KIND_LOAD, 8'h03, 32'hFFFF_FF2B, 6'd7));
        send_word(make_word(KIND_ENCODE, 8'h55, '0, '0));
        send_word(make_word(KIND_ENCODE, 8'h02, '0, '0));
        send_word(make_word(KIND_ENCODE, 8'h03, '0, '0));
        send_word(make_word(KIND_ENCODE, 8'hFF, '0, '0));
        send_word(make_word(KIND_ENCODE, 8'h03, '0, '0));
        // Seven pending bits plus a full code give four bytes at once.
        send_word(make_word(KIND_ENCODE, 8'h00, '0, '0));
        send_word(make_word(KIND_ENCODE, 8'hAA, '1, '1));
        send_word(make_word(KIND_ENCODE, 8'h01, '0, '0));
        send_word(make_word(KIND_FLUSH, 8'h00, '0, '0));
        send_word(make_word(KIND_FLUSH, 8'hFF, '1, '1));
        send_word(make_word(KIND_UNUSED, 8'h55, 32'h5555_5555, 6'd21));
        send_word(make_word(KIND_ENCODE, 8'hFF, '0, '0));
        send_word(make_word(KIND_FLUSH, 8'h00, '0, '0));
        send_word(make_word(KIND_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd0));
        send_word(make_word(KIND_ENCODE, 8'h00, '0, '0));
        send_word(make_word(KIND_ENCODE, 8'h01, '0, '0));
        send_word(make_word(KIND_FLUSH, 8'h00, '0, '0));
        wait_drained();
    endtask

    // A random stream: mostly encodes of a small symbol pool, with loads and flushes.
    task automatic test_random_stream(input int count);
        int             pick;
        logic [KIND_W-1:0] kind;
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                kind = KIND_LOAD;
            else if (pick < 80)
                kind = KIND_ENCODE;
            else if (pick < 94)
                kind = KIND_FLUSH;
            else
                kind = KIND_UNUSED;
            if ($urandom_range(0, 99) < 85)
                sym = sym_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                sym = SYM_W'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 8)
                len = '0;
            else if (pick < 16)
                len = LEN_W'($urandom_range(LEN_LIMIT + 1, 63));
            else
                len = LEN_W'($urandom_range(1, LEN_LIMIT));
            send_word(make_word(kind, sym, $urandom, len));
        end
    endtask

    // The same stream with neither side idling.
    task automatic test_unbroken_stream(input int count);
        no_idle = 1'b1;
        test_random_stream(count);
        wait_drained();
        no_idle = 1'b0;
    endtask

    initial
    begin
        foreach (sym_pool[k])
            sym_pool[k] = SYM_W'($urandom_range(0, 255));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_directed_codes();
        test_random_stream(180);
        wait_drained();
        test_unbroken_stream(120);
        test_random_stream(150);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
